FILE: rtl/mkc_pkg.sv
// shared types, constants and rounding helper for the median/kalman sensor channel
// no dependencies
package mkc_pkg;

  localparam int WINDOW = 5;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SMP_W  = 20;
  localparam int K_W    = 17;
  localparam int DIV_CNT_W = $clog2(K_W);

  localparam logic [2:0] REG_PROCESS_NOISE     = 3'd0;
  localparam logic [2:0] REG_MEASUREMENT_NOISE = 3'd1;
  localparam logic [2:0] REG_CAL_SLOPE         = 3'd2;
  localparam logic [2:0] REG_CAL_OFFSET        = 3'd3;
  localparam logic [2:0] REG_OUT_MAX           = 3'd4;

  typedef struct packed {
    logic                    done;
    logic signed [SMP_W-1:0] median;
  } med_res_t;

  typedef struct packed {
    logic           done;
    logic [K_W-1:0] k;
  } div_res_t;

  // round(x / 65536), halves away from zero
  function automatic logic signed [38:0] round_q16(input logic signed [54:0] x);
    logic        [54:0] mag;
    logic        [54:0] sum;
    logic        [38:0] rmag;
    mag  = x[54] ? 55'(-x) : 55'(x);
    sum  = mag + 55'd32768;
    rmag = sum[54:16];
    return x[54] ? 39'(-rmag) : 39'(rmag);
  endfunction

endpackage

FILE: rtl/mkc_window.sv
// sample ring and rank-count median search, one candidate per cycle
// depends on mkc_pkg
module mkc_window import mkc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr,
  input  logic signed [SMP_W-1:0] sample,
  output med_res_t                res
);

  logic signed [SMP_W-1:0] win_r [WINDOW];
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             full_r, full_nxt;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] cand_r;
  logic             busy_r;
  logic signed [SMP_W-1:0] med_r;
  logic             done_r;
  logic signed [SMP_W-1:0] cand;
  logic [CNT_W-1:0] rank;

  always_comb begin
    if (slot_r == IDX_W'(WINDOW - 1)) begin
      slot_nxt = '0;
      full_nxt = 1'b1;
    end else begin
      slot_nxt = slot_r + 1'b1;
      full_nxt = full_r;
    end
  end

  // stable rank of the candidate among the held samples
  always_comb begin
    cand = win_r[cand_r];
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((CNT_W'(j) < count_r) &&
          ((win_r[j] < cand) || ((win_r[j] == cand) && (IDX_W'(j) < cand_r))))
        rank = rank + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) win_r[slot_r] <= sample;
    if (busy_r && (rank == (count_r >> 1))) med_r <= cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      full_r  <= 1'b0;
      count_r <= '0;
      cand_r  <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (wr) begin
        slot_r  <= slot_nxt;
        full_r  <= full_nxt;
        count_r <= full_nxt ? CNT_W'(WINDOW) : CNT_W'(slot_nxt);
        cand_r  <= '0;
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        if (CNT_W'(cand_r) == count_r - 1'b1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cand_r <= cand_r + 1'b1;
        end
      end
    end
  end

  assign res.done   = done_r;
  assign res.median = med_r;

endmodule

FILE: rtl/mkc_div.sv
// restoring divider for the kalman gain, one quotient bit per cycle
// depends on mkc_pkg
module mkc_div import mkc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [32:0] den,
  output div_res_t    res
);

  logic [33:0]          rem_r;
  logic [32:0]          den_r;
  logic [K_W-1:0]       q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r, zero_r;
  logic                 ge;
  logic [33:0]          diff;

  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b0, num};
      den_r  <= den;
      zero_r <= (den == '0);
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= {diff[32:0], 1'b0};
      q_r   <= {q_r[K_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(K_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.k    = zero_r ? '0 : q_r;

endmodule

FILE: rtl/median_kalman_sensor_channel.sv
// top level: median of five, scalar kalman filter, linear calibration with clamp
// depends on mkc_pkg, mkc_window, mkc_div
//
// One probe voltage item in (signed Q16 volts), one result out per item. The
// ring keeps the last five samples; the median over the samples held so far
// (upper middle for an even count) feeds a scalar kalman filter whose estimate
// is mapped as slope * estimate + offset and clamped to 0..out_max. The median
// search visits one candidate per cycle over the 1..5 held samples, the gain
// divider yields one quotient bit per cycle (17 bits), and a single shared
// multiplier does the three products one after another; for the first item
// after reset the median only loads the estimate, so the divider and the first
// two products are skipped. in_tready comes back in the same cycle as the
// result appears. in_tready is high only while the sequencer is idle; the
// result sits in an output register, so the next item is taken while it waits.
// cfg writes are always ready and take effect at once.
module median_kalman_sensor_channel import mkc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] sample_volts
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [19:0] median_volts, [39:20] filtered_volts, [70:40] value
  output logic [0:0]  out_tuser,  // [0] saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MED  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_MK   = 7'b0001000,
    ST_MP   = 7'b0010000,
    ST_CAL  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0]        q_noise_r;
  logic [21:0]        r_noise_r;
  logic signed [31:0] slope_r;
  logic signed [31:0] offset_r;
  logic [30:0]        out_max_r;

  // filter state
  logic signed [SMP_W-1:0] est_r;
  logic [31:0]             var_r;
  logic                    primed_r;
  logic                    var_pend_r;

  // working registers
  logic signed [SMP_W-1:0] med_r;
  logic [31:0]             p_r;
  logic [K_W-1:0]          k_r;
  logic signed [54:0]      prod_r;

  // output register
  logic                    out_valid_r;
  logic [71:0]             out_data_r;
  logic                    out_sat_r;

  med_res_t med_res;
  div_res_t div_res;

  logic        in_acc;
  logic [32:0] p_sum;
  logic [31:0] p_sat;
  logic [32:0] den;
  logic        div_start;

  logic signed [32:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [54:0] mul_p;
  logic signed [38:0] rnd;
  logic signed [SMP_W:0] diff;
  logic [K_W-1:0]     omk;
  logic signed [39:0] val;
  logic [30:0]        val_clamped;
  logic               val_sat;
  logic               out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // variance plus process noise, saturating, and the gain denominator
  assign p_sum     = {1'b0, var_r} + {17'b0, q_noise_r};
  assign p_sat     = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
  assign den       = {1'b0, p_sat} + {11'b0, r_noise_r};
  assign div_start = (state_r == ST_MED) && med_res.done && primed_r;

  mkc_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (in_acc),
    .sample (in_tdata[SMP_W-1:0]),
    .res    (med_res)
  );

  mkc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p_sat),
    .den   (den),
    .res   (div_res)
  );

  // shared multiplier operand selection
  assign diff = {med_r[SMP_W-1], med_r} - {est_r[SMP_W-1], est_r};
  assign omk  = K_W'(17'd65536 - k_r);

  always_comb begin
    case (state_r)
      ST_MK: begin
        mul_a = 33'(diff);
        mul_b = {5'b0, k_r};
      end
      ST_MP: begin
        mul_a = {1'b0, p_r};
        mul_b = {5'b0, omk};
      end
      ST_CAL: begin
        mul_a = {slope_r[31], slope_r};
        mul_b = {{2{est_r[SMP_W-1]}}, est_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign rnd   = round_q16(prod_r);

  // calibration and clamp
  assign val = {rnd[38], rnd} + {{8{offset_r[31]}}, offset_r};
  always_comb begin
    if (val[39]) begin
      val_clamped = '0;
      val_sat     = 1'b1;
    end else if (val > {9'b0, out_max_r}) begin
      val_clamped = out_max_r;
      val_sat     = 1'b1;
    end else begin
      val_clamped = val[30:0];
      val_sat     = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MED;
      ST_MED:  if (med_res.done) state_nxt = primed_r ? ST_DIV : ST_CAL;
      ST_DIV:  if (div_res.done) state_nxt = ST_MK;
      ST_MK:   state_nxt = ST_MP;
      ST_MP:   state_nxt = ST_CAL;
      ST_CAL:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MED: begin
        if (med_res.done) begin
          med_r <= med_res.median;
          p_r   <= p_sat;
        end
      end
      ST_DIV: if (div_res.done) k_r <= div_res.k;
      ST_MK:  prod_r <= mul_p;
      ST_MP:  prod_r <= mul_p;
      ST_CAL: prod_r <= mul_p;
      default: ;
    endcase
    if (state_r == ST_FIN && out_free) begin
      out_data_r <= {1'b0, val_clamped, est_r, med_r};
      out_sat_r  <= val_sat;
    end
  end

  // control, filter state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_noise_r   <= 16'd66;
      r_noise_r   <= 22'd3277;
      slope_r     <= -32'sd327680;
      offset_r    <= 32'sd1398538;
      out_max_r   <= 31'd917504;
      est_r       <= '0;
      var_r       <= 32'd65536;
      primed_r    <= 1'b0;
      var_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_PROCESS_NOISE:     q_noise_r <= cfg_data[15:0];
          REG_MEASUREMENT_NOISE: r_noise_r <= cfg_data[21:0];
          REG_CAL_SLOPE:         slope_r   <= cfg_data;
          REG_CAL_OFFSET:        offset_r  <= cfg_data;
          REG_OUT_MAX:           out_max_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      // first median only loads the estimate
      if (state_r == ST_MED && med_res.done && !primed_r) begin
        est_r    <= med_res.median;
        primed_r <= 1'b1;
      end
      // estimate update from the gain times innovation product
      if (state_r == ST_MP) begin
        est_r      <= est_r + rnd[SMP_W-1:0];
        var_pend_r <= 1'b1;
      end
      // variance update from the (1 - k) * p product
      if (state_r == ST_CAL && var_pend_r) begin
        var_r      <= rnd[31:0];
        var_pend_r <= 1'b0;
      end
      if (state_r == ST_FIN && out_free)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // checks
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("gain divider finished outside its step");

  a_med_in_med_state: assert property (@(posedge clk) disable iff (!rst_n)
    med_res.done |-> (state_r == ST_MED))
    else $error("median search finished outside its step");

  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[70:40] <= out_max_r))
    else $error("calibrated value above limit");

  a_prime_once: assert property (@(posedge clk) disable iff (!rst_n)
    $past(primed_r) |-> primed_r)
    else $error("filter lost its primed flag");

endmodule

FILE: verif/tb_top.sv
// self-checking bench for the median/kalman sensor channel: directed and random sample stream,
// own behavioural prediction, field-by-field check of every result item
// depends on mkc_pkg and median_kalman_sensor_channel
module tb_top import mkc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [19:0] med;
    logic signed [19:0] est;
    logic [30:0]        val;
    logic               sat;
  } chan_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  median_kalman_sensor_channel dut (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predictor state: registers and filter state
  logic [15:0]        q_noise;
  logic [21:0]        r_noise;
  logic signed [31:0] slope;
  logic signed [31:0] offset;
  logic [30:0]        vmax;
  logic signed [19:0] ring [WINDOW];
  int                 slot;
  bit                 ring_full;
  logic signed [19:0] est_q16;
  logic [31:0]        var_q16;
  bit                 primed;

  logic [19:0]  sample_q [$];
  chan_result_t expected_q [$];
  int           errors;
  bit           hold_off;

  // round(x/65536) with halves away from zero
  function automatic longint div_round(longint x);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + 32768) >>> 16;
    return (x < 0) ? -m : m;
  endfunction

  function automatic chan_result_t filter_step(logic signed [19:0] smp);
    chan_result_t r;
    int cnt;
    int i;
    int j;
    logic signed [19:0] srt [WINDOW];
    logic signed [19:0] key;
    longint unsigned p;
    longint unsigned den;
    longint unsigned k;
    longint diff;
    longint v;
    ring[slot] = smp;
    slot++;
    if (slot >= WINDOW) begin
      slot = 0;
      ring_full = 1;
    end
    cnt = ring_full ? WINDOW : slot;
    for (i = 0; i < cnt; i++) srt[i] = ring[i];
    for (i = 1; i < cnt; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    r.med = srt[cnt/2];
    if (!primed) begin
      est_q16 = r.med;
      primed = 1;
    end else begin
      p = longint'(var_q16) + q_noise;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      den = p + r_noise;
      k = (den == 0) ? 0 : (p << 16) / den;
      if (k > 65536) k = 65536;
      diff = longint'(r.med) - longint'(est_q16);
      est_q16 = 20'(longint'(est_q16) + div_round(longint'(k) * diff));
      var_q16 = 32'(((65536 - k) * p + 32768) >> 16);
    end
    r.est = est_q16;
    v = div_round(longint'(slope) * longint'(est_q16)) + longint'(offset);
    r.sat = 1'b0;
    if (v < 0) begin
      r.val = '0;
      r.sat = 1'b1;
    end else if (v > longint'(vmax)) begin
      r.val = vmax;
      r.sat = 1'b1;
    end else begin
      r.val = 31'(v);
    end
    return r;
  endfunction

  // driver: bursts of items with random gaps, fed from sample_q
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      gap_left  <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the item until taken
    end else begin
      if (in_tvalid) expected_q.push_back(filter_step(signed'(in_tdata[19:0])));
      if (gap_left > 0 || hold_off || sample_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, sample_q.pop_front()};
        if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 60);
      end
    end
  end

  // receiver stalls: alternating ready/stall runs of random length
  int stall_run;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_run  <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_tready <= !out_tready;
      stall_run  <= out_tready ? $urandom_range(0, 40) : $urandom_range(0, 90);
    end
  end

  // monitor
  always @(posedge clk) begin
    chan_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, out_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[19:0] !== e.med) begin
          $display("%0t: median exp %0d got %0d", $time, e.med, signed'(out_tdata[19:0]));
          errors++;
        end
        if (out_tdata[39:20] !== e.est) begin
          $display("%0t: estimate exp %0d got %0d", $time, e.est,
                   signed'(out_tdata[39:20]));
          errors++;
        end
        if (out_tdata[70:40] !== e.val) begin
          $display("%0t: value exp %0d got %0d", $time, e.val, out_tdata[70:40]);
          errors++;
        end
        if (out_tuser[0] !== e.sat) begin
          $display("%0t: saturated exp %0b got %0b", $time, e.sat, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  // one write, then cfg_valid is dropped before returning so that writes never overlap
  task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE:     q_noise = d[15:0];
      REG_MEASUREMENT_NOISE: r_noise = d[21:0];
      REG_CAL_SLOPE:         slope = d;
      REG_CAL_OFFSET:        offset = d;
      REG_OUT_MAX:           vmax = d[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for all queued items to be taken and every result item to return
  task automatic drain();
    while (sample_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 20'(-268435);
      1: return 20'(268435);
      2: return 20'($urandom_range(0, 1000)) - 20'd500;
      3: return 20'($urandom_range(0, 20000)) + 20'd50000;
      default: return 20'($urandom_range(0, 536870)) - 20'd268435;
    endcase
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) sample_q.push_back(rand_sample());
  endtask

  initial begin
    int ph;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; hold_off = 0;
    q_noise = 16'd66; r_noise = 22'd3277; slope = -32'sd327680;
    offset = 32'sd1398538; vmax = 31'd917504;
    slot = 0; ring_full = 0; est_q16 = '0; var_q16 = 32'd65536; primed = 0;
    foreach (ring[i]) ring[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ring fill, upper middle for even counts, range extremes, clamps
    sample_q = '{20'd1000, 20'd3000, 20'd2000, 20'(-268435), 20'd268435,
                 20'd268435, 20'd268435, 20'd0, 20'(-1), 20'h80000 + 20'd6000,
                 20'd65536, 20'd7, 20'(-65536), 20'd196608, 20'd131072};
    drain();
    // zero gain denominator needs Q = 0 and R = 0; out_max extremes
    cfg_write(REG_PROCESS_NOISE, 32'd0);
    cfg_write(REG_MEASUREMENT_NOISE, 32'd0);
    cfg_write(REG_OUT_MAX, 32'h7FFF_FFFF);
    sample_q = '{20'd5000, 20'(-5000), 20'd268435, 20'(-268435)};
    drain();
    // an index past the register file is ignored
    cfg_write(3'd7, 32'hFFFF_FFFF);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_PROCESS_NOISE, 32'd65535);
          cfg_write(REG_MEASUREMENT_NOISE, 32'h3F_FFFF);
          cfg_write(REG_CAL_SLOPE, 32'h7FFF_FFFF);
          cfg_write(REG_CAL_OFFSET, 32'h8000_0000);
          cfg_write(REG_OUT_MAX, 32'd0);
        end
        1: begin
          cfg_write(REG_MEASUREMENT_NOISE, 32'd1);
          cfg_write(REG_CAL_SLOPE, 32'h8000_0000);
          cfg_write(REG_CAL_OFFSET, 32'h7FFF_FFFF);
          cfg_write(REG_OUT_MAX, 32'h7FFF_FFFF);
        end
        2: begin
          cfg_write(REG_PROCESS_NOISE, 32'd66);
          cfg_write(REG_MEASUREMENT_NOISE, 32'd3277);
          cfg_write(REG_CAL_SLOPE, -32'sd327680);
          cfg_write(REG_CAL_OFFSET, 32'd1398538);
          cfg_write(REG_OUT_MAX, 32'd917504);
        end
        default: begin
          cfg_write(REG_PROCESS_NOISE, $urandom_range(0, 65535));
          cfg_write(REG_MEASUREMENT_NOISE, $urandom_range(0, 4194303));
          cfg_write(REG_CAL_SLOPE, $urandom);
          cfg_write(REG_CAL_OFFSET, $urandom);
          cfg_write(REG_OUT_MAX, $urandom_range(0, 32'h7FFF_FFFF));
        end
      endcase
      random_burst(40);
      // part way through the burst the sender holds off until every
      // result item is back, then resumes
      while (sample_q.size() > 20) @(posedge clk);
      hold_off = 1;
      @(posedge clk);
      while (in_tvalid || expected_q.size() != 0) @(posedge clk);
      hold_off = 0;
      random_burst(37);
      drain();
    end
    if (errors == 0) begin
      $display("median_kalman_sensor_channel test passed");
    end else begin
      $display("median_kalman_sensor_channel test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("median_kalman_sensor_channel test failed");
    $finish;
  end
endmodule
